FILE: rtl/jsvp_pkg.sv
// Package with codes, types and helper functions of the JSON scalar value parser.
package jsvp_pkg;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned MAX_RES = 4;
    localparam int unsigned CNT_W   = 3;

    localparam logic [PHASE_W-1:0] PH_LEAD   = 5'd0;
    localparam logic [PHASE_W-1:0] PH_LIT    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_NSIGN  = 5'd2;
    localparam logic [PHASE_W-1:0] PH_NZERO  = 5'd3;
    localparam logic [PHASE_W-1:0] PH_NINT   = 5'd4;
    localparam logic [PHASE_W-1:0] PH_NDOT   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_NFRAC  = 5'd6;
    localparam logic [PHASE_W-1:0] PH_NE     = 5'd7;
    localparam logic [PHASE_W-1:0] PH_NESIGN = 5'd8;
    localparam logic [PHASE_W-1:0] PH_NEXP   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_STR    = 5'd10;
    localparam logic [PHASE_W-1:0] PH_ESC    = 5'd11;
    localparam logic [PHASE_W-1:0] PH_HEX    = 5'd12;
    localparam logic [PHASE_W-1:0] PH_SURBS  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_SURU   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_HEXLO  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_TRAIL  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_ERR    = 5'd17;

    localparam logic [CODE_W-1:0] ST_OK      = 4'd0;
    localparam logic [CODE_W-1:0] ST_EXPECT  = 4'd1;
    localparam logic [CODE_W-1:0] ST_INVALID = 4'd2;
    localparam logic [CODE_W-1:0] ST_NOTSING = 4'd3;
    localparam logic [CODE_W-1:0] ST_QUOTE   = 4'd4;
    localparam logic [CODE_W-1:0] ST_ESCAPE  = 4'd5;
    localparam logic [CODE_W-1:0] ST_CHAR    = 4'd6;
    localparam logic [CODE_W-1:0] ST_HEX     = 4'd7;
    localparam logic [CODE_W-1:0] ST_SURR    = 4'd8;

    localparam logic [KIND_W-1:0] K_NULL   = 3'd0;
    localparam logic [KIND_W-1:0] K_FALSE  = 3'd1;
    localparam logic [KIND_W-1:0] K_TRUE   = 3'd2;
    localparam logic [KIND_W-1:0] K_NUMBER = 3'd3;
    localparam logic [KIND_W-1:0] K_STRING = 3'd4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_    = 8'h66;
    localparam logic [7:0] CH_LL     = 8'h6C;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LS     = 8'h73;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_CTRL   = 8'h20;

    localparam logic [7:0] ESC_BS = 8'h08;
    localparam logic [7:0] ESC_FF = 8'h0C;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [20:0] MAX_ONE    = 21'h7F;
    localparam logic [20:0] MAX_TWO    = 21'h7FF;
    localparam logic [20:0] MAX_THREE  = 21'hFFFF;
    localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF_LEAD4  = 8'hF0;
    localparam logic [7:0]  UTF_CONT   = 8'h80;

    typedef struct packed {
        logic [7:0]        data;
        logic              stat;
        logic [CODE_W-1:0] code;
        logic [KIND_W-1:0] kind;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        logic [MAX_RES-1:0][7:0]   bytes;
    } t_utf8;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= CH_0 && b <= CH_9) begin
            d = b - CH_0;
            return {1'b1, d[3:0]};
        end else if (b >= CH_UA && b <= CH_UF) begin
            d = b - CH_UA + 8'd10;
            return {1'b1, d[3:0]};
        end else if (b >= CH_LA && b <= CH_LF_) begin
            d = b - CH_LA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] k);
        return (k == K_FALSE[1:0]) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (k == K_NULL[1:0]) begin
            case (pos)
                3'd0: c = CH_LN;
                3'd1: c = CH_LU;
                3'd2: c = CH_LL;
                3'd3: c = CH_LL;
                default: c = 8'h00;
            endcase
        end else if (k == K_FALSE[1:0]) begin
            case (pos)
                3'd0: c = CH_LF_;
                3'd1: c = CH_LA;
                3'd2: c = CH_LL;
                3'd3: c = CH_LS;
                3'd4: c = CH_LE;
                default: c = 8'h00;
            endcase
        end else begin
            case (pos)
                3'd0: c = CH_LT;
                3'd1: c = CH_LR;
                3'd2: c = CH_LU;
                3'd3: c = CH_LE;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] u);
        t_utf8 r;
        r.bytes = '0;
        if (u <= MAX_ONE) begin
            r.cnt = 3'd1;
            r.bytes[0] = u[7:0];
        end else if (u <= MAX_TWO) begin
            r.cnt = 3'd2;
            r.bytes[0] = UTF_LEAD2 | {3'b000, u[10:6]};
            r.bytes[1] = UTF_CONT | {2'b00, u[5:0]};
        end else if (u <= MAX_THREE) begin
            r.cnt = 3'd3;
            r.bytes[0] = UTF_LEAD3 | {4'b0000, u[15:12]};
            r.bytes[1] = UTF_CONT | {2'b00, u[11:6]};
            r.bytes[2] = UTF_CONT | {2'b00, u[5:0]};
        end else begin
            r.cnt = 3'd4;
            r.bytes[0] = UTF_LEAD4 | {5'b00000, u[20:18]};
            r.bytes[1] = UTF_CONT | {2'b00, u[17:12]};
            r.bytes[2] = UTF_CONT | {2'b00, u[11:6]};
            r.bytes[3] = UTF_CONT | {2'b00, u[5:0]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/json_scalar_value_parser_top.sv
// Top level of the JSON scalar value parser: byte-wise checker and result buffer.
// Results of an accepted byte are registered and appear on the output in the cycle after acceptance.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output takes it; a byte that yields k results (up to four for a \u escape) blocks
// input until its last result is taken, since the four-entry result buffer drains one per ready cycle.
// Reset: synchronous active-low reset returns the parser to leading whitespace and empties the buffer.
module json_scalar_value_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] data_byte, [11:8] status_code,
                                          // [14:12] value_kind, [15] zero
    output logic        o_m_axis_tuser,   // [0] is_status
    output logic        o_m_axis_tlast    // run_last
);

    localparam int unsigned RES = jsvp_pkg::MAX_RES;

    logic [jsvp_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [2:0]                   r_lpos, n_lpos;
    logic [jsvp_pkg::CODE_W-1:0]  r_err, n_err;
    logic [jsvp_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [15:0]                  r_hacc, n_hacc;
    logic [1:0]                   r_hcnt, n_hcnt;
    logic [9:0]                   r_hsur, n_hsur;

    jsvp_pkg::t_item              r_item [RES];
    jsvp_pkg::t_item              n_item [RES];
    jsvp_pkg::t_item              res_item [RES];
    logic [jsvp_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    logic                         in_acc;
    logic                         out_pop;
    logic [7:0]                   b;
    logic [4:0]                   hv;
    logic [15:0]                  hacc_sh;
    logic [20:0]                  supp;
    jsvp_pkg::t_utf8              enc_bmp;
    jsvp_pkg::t_utf8              enc_sup;
    logic [1:0]                   lk;
    logic [2:0]                   lpos_inc;

    logic [jsvp_pkg::CNT_W-1:0]   v_cnt;
    logic [RES-1:0][7:0]          v_data;
    logic                         v_stat;
    logic [jsvp_pkg::CODE_W-1:0]  v_code;
    logic [jsvp_pkg::KIND_W-1:0]  v_kind;

    assign b        = i_s_axis_tdata;
    assign o_s_axis_tready = (r_cnt == '0) || ((r_cnt == jsvp_pkg::CNT_W'(1)) && i_m_axis_tready);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign out_pop  = o_m_axis_tvalid && i_m_axis_tready;

    assign o_m_axis_tdata = {1'b0, r_item[0].kind, r_item[0].code, r_item[0].data};
    assign o_m_axis_tuser = r_item[0].stat;
    assign o_m_axis_tlast = r_item[0].last;

    assign hv       = jsvp_pkg::hex_val(b);
    assign hacc_sh  = {r_hacc[11:0], hv[3:0]};
    assign supp     = {1'b0, r_hsur, hacc_sh[9:0]} + jsvp_pkg::SUPP_BASE;
    assign enc_bmp  = jsvp_pkg::utf8_enc({5'b00000, hacc_sh});
    assign enc_sup  = jsvp_pkg::utf8_enc(supp);
    assign lk       = (r_kind > jsvp_pkg::K_TRUE) ? jsvp_pkg::K_TRUE[1:0] : r_kind[1:0];
    assign lpos_inc = r_lpos + 3'd1;

    always_comb begin
        n_phase = r_phase;
        n_lpos  = r_lpos;
        n_err   = r_err;
        n_kind  = r_kind;
        n_hacc  = r_hacc;
        n_hcnt  = r_hcnt;
        n_hsur  = r_hsur;
        v_cnt   = '0;
        v_data  = '0;
        v_stat  = 1'b0;
        v_code  = jsvp_pkg::ST_OK;
        v_kind  = jsvp_pkg::K_NULL;
        if (i_s_axis_tlast) begin
            v_cnt  = jsvp_pkg::CNT_W'(1);
            v_stat = 1'b1;
            unique case (r_phase) inside
                jsvp_pkg::PH_LEAD: v_code = jsvp_pkg::ST_EXPECT;
                jsvp_pkg::PH_NZERO, jsvp_pkg::PH_NINT, jsvp_pkg::PH_NFRAC,
                jsvp_pkg::PH_NEXP: begin
                    v_code = jsvp_pkg::ST_OK;
                    v_kind = jsvp_pkg::K_NUMBER;
                end
                jsvp_pkg::PH_STR: v_code = jsvp_pkg::ST_QUOTE;
                jsvp_pkg::PH_ESC: v_code = jsvp_pkg::ST_ESCAPE;
                jsvp_pkg::PH_HEX, jsvp_pkg::PH_HEXLO: v_code = jsvp_pkg::ST_HEX;
                jsvp_pkg::PH_SURBS, jsvp_pkg::PH_SURU: v_code = jsvp_pkg::ST_SURR;
                jsvp_pkg::PH_TRAIL: begin
                    v_code = jsvp_pkg::ST_OK;
                    v_kind = r_kind;
                end
                jsvp_pkg::PH_ERR: v_code = r_err;
                default: v_code = jsvp_pkg::ST_INVALID;
            endcase
            n_phase = jsvp_pkg::PH_LEAD;
            n_lpos  = '0;
            n_err   = jsvp_pkg::ST_OK;
            n_kind  = jsvp_pkg::K_NULL;
            n_hacc  = '0;
            n_hcnt  = '0;
            n_hsur  = '0;
        end else begin
            unique case (r_phase)
                jsvp_pkg::PH_LEAD: begin
                    if (!jsvp_pkg::is_ws(b)) begin
                        if (b == jsvp_pkg::CH_LN || b == jsvp_pkg::CH_LF_ || b == jsvp_pkg::CH_LT) begin
                            n_kind  = (b == jsvp_pkg::CH_LN)  ? jsvp_pkg::K_NULL :
                                      (b == jsvp_pkg::CH_LF_) ? jsvp_pkg::K_FALSE :
                                                                jsvp_pkg::K_TRUE;
                            n_lpos  = 3'd1;
                            n_phase = jsvp_pkg::PH_LIT;
                        end else if (b == jsvp_pkg::CH_QUOTE) begin
                            n_phase = jsvp_pkg::PH_STR;
                        end else if (b == jsvp_pkg::CH_MINUS) begin
                            n_phase = jsvp_pkg::PH_NSIGN;
                        end else if (b == jsvp_pkg::CH_0) begin
                            n_phase = jsvp_pkg::PH_NZERO;
                        end else if (b >= jsvp_pkg::CH_1 && b <= jsvp_pkg::CH_9) begin
                            n_phase = jsvp_pkg::PH_NINT;
                        end else begin
                            n_err   = jsvp_pkg::ST_INVALID;
                            n_phase = jsvp_pkg::PH_ERR;
                        end
                    end
                end
                jsvp_pkg::PH_LIT: begin
                    if (r_lpos >= jsvp_pkg::lit_len(lk) || b != jsvp_pkg::lit_char(lk, r_lpos)) begin
                        n_err   = jsvp_pkg::ST_INVALID;
                        n_phase = jsvp_pkg::PH_ERR;
                    end else begin
                        n_lpos = lpos_inc;
                        if (lpos_inc == jsvp_pkg::lit_len(lk)) begin
                            n_phase = jsvp_pkg::PH_TRAIL;
                        end
                    end
                end
                jsvp_pkg::PH_NSIGN: begin
                    if (b == jsvp_pkg::CH_0) begin
                        n_phase = jsvp_pkg::PH_NZERO;
                    end else if (b >= jsvp_pkg::CH_1 && b <= jsvp_pkg::CH_9) begin
                        n_phase = jsvp_pkg::PH_NINT;
                    end else begin
                        n_err   = jsvp_pkg::ST_INVALID;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_NZERO, jsvp_pkg::PH_NINT, jsvp_pkg::PH_NFRAC: begin
                    if (jsvp_pkg::is_digit(b) && r_phase != jsvp_pkg::PH_NZERO) begin
                        n_phase = r_phase;
                    end else if (b == jsvp_pkg::CH_DOT && r_phase != jsvp_pkg::PH_NFRAC) begin
                        n_phase = jsvp_pkg::PH_NDOT;
                    end else if (b == jsvp_pkg::CH_LE || b == jsvp_pkg::CH_UE) begin
                        n_phase = jsvp_pkg::PH_NE;
                    end else begin
                        n_kind = jsvp_pkg::K_NUMBER;
                        if (jsvp_pkg::is_ws(b)) begin
                            n_phase = jsvp_pkg::PH_TRAIL;
                        end else begin
                            n_err   = jsvp_pkg::ST_NOTSING;
                            n_phase = jsvp_pkg::PH_ERR;
                        end
                    end
                end
                jsvp_pkg::PH_NDOT: begin
                    if (jsvp_pkg::is_digit(b)) begin
                        n_phase = jsvp_pkg::PH_NFRAC;
                    end else begin
                        n_err   = jsvp_pkg::ST_INVALID;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_NE: begin
                    if (b == jsvp_pkg::CH_PLUS || b == jsvp_pkg::CH_MINUS) begin
                        n_phase = jsvp_pkg::PH_NESIGN;
                    end else if (jsvp_pkg::is_digit(b)) begin
                        n_phase = jsvp_pkg::PH_NEXP;
                    end else begin
                        n_err   = jsvp_pkg::ST_INVALID;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_NESIGN: begin
                    if (jsvp_pkg::is_digit(b)) begin
                        n_phase = jsvp_pkg::PH_NEXP;
                    end else begin
                        n_err   = jsvp_pkg::ST_INVALID;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_NEXP: begin
                    if (!jsvp_pkg::is_digit(b)) begin
                        n_kind = jsvp_pkg::K_NUMBER;
                        if (jsvp_pkg::is_ws(b)) begin
                            n_phase = jsvp_pkg::PH_TRAIL;
                        end else begin
                            n_err   = jsvp_pkg::ST_NOTSING;
                            n_phase = jsvp_pkg::PH_ERR;
                        end
                    end
                end
                jsvp_pkg::PH_STR: begin
                    if (b == jsvp_pkg::CH_QUOTE) begin
                        n_kind  = jsvp_pkg::K_STRING;
                        n_phase = jsvp_pkg::PH_TRAIL;
                    end else if (b == jsvp_pkg::CH_BSLASH) begin
                        n_phase = jsvp_pkg::PH_ESC;
                    end else if (b < jsvp_pkg::CH_CTRL) begin
                        n_err   = jsvp_pkg::ST_CHAR;
                        n_phase = jsvp_pkg::PH_ERR;
                    end else begin
                        v_cnt     = jsvp_pkg::CNT_W'(1);
                        v_data[0] = b;
                    end
                end
                jsvp_pkg::PH_ESC: begin
                    n_phase = jsvp_pkg::PH_STR;
                    case (b) inside
                        jsvp_pkg::CH_QUOTE, jsvp_pkg::CH_BSLASH, jsvp_pkg::CH_SLASH: begin
                            v_cnt     = jsvp_pkg::CNT_W'(1);
                            v_data[0] = b;
                        end
                        jsvp_pkg::CH_LB: begin
                            v_cnt     = jsvp_pkg::CNT_W'(1);
                            v_data[0] = jsvp_pkg::ESC_BS;
                        end
                        jsvp_pkg::CH_LF_: begin
                            v_cnt     = jsvp_pkg::CNT_W'(1);
                            v_data[0] = jsvp_pkg::ESC_FF;
                        end
                        jsvp_pkg::CH_LN: begin
                            v_cnt     = jsvp_pkg::CNT_W'(1);
                            v_data[0] = jsvp_pkg::CH_LF;
                        end
                        jsvp_pkg::CH_LR: begin
                            v_cnt     = jsvp_pkg::CNT_W'(1);
                            v_data[0] = jsvp_pkg::CH_CR;
                        end
                        jsvp_pkg::CH_LT: begin
                            v_cnt     = jsvp_pkg::CNT_W'(1);
                            v_data[0] = jsvp_pkg::CH_TAB;
                        end
                        jsvp_pkg::CH_LU: begin
                            n_hacc  = '0;
                            n_hcnt  = '0;
                            n_phase = jsvp_pkg::PH_HEX;
                        end
                        default: begin
                            n_err   = jsvp_pkg::ST_ESCAPE;
                            n_phase = jsvp_pkg::PH_ERR;
                        end
                    endcase
                end
                jsvp_pkg::PH_HEX: begin
                    if (!hv[4]) begin
                        n_err   = jsvp_pkg::ST_HEX;
                        n_phase = jsvp_pkg::PH_ERR;
                    end else begin
                        n_hacc = hacc_sh;
                        if (r_hcnt == 2'd3) begin
                            n_hcnt = '0;
                            if (hacc_sh >= jsvp_pkg::SUR_HI_MIN && hacc_sh <= jsvp_pkg::SUR_HI_MAX) begin
                                n_hsur  = hacc_sh[9:0];
                                n_phase = jsvp_pkg::PH_SURBS;
                            end else begin
                                v_cnt   = enc_bmp.cnt;
                                v_data  = enc_bmp.bytes;
                                n_phase = jsvp_pkg::PH_STR;
                            end
                        end else begin
                            n_hcnt = r_hcnt + 2'd1;
                        end
                    end
                end
                jsvp_pkg::PH_SURBS: begin
                    if (b == jsvp_pkg::CH_BSLASH) begin
                        n_phase = jsvp_pkg::PH_SURU;
                    end else begin
                        n_err   = jsvp_pkg::ST_SURR;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_SURU: begin
                    if (b == jsvp_pkg::CH_LU) begin
                        n_hacc  = '0;
                        n_hcnt  = '0;
                        n_phase = jsvp_pkg::PH_HEXLO;
                    end else begin
                        n_err   = jsvp_pkg::ST_SURR;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_HEXLO: begin
                    if (!hv[4]) begin
                        n_err   = jsvp_pkg::ST_HEX;
                        n_phase = jsvp_pkg::PH_ERR;
                    end else begin
                        n_hacc = hacc_sh;
                        if (r_hcnt == 2'd3) begin
                            n_hcnt = '0;
                            if (hacc_sh < jsvp_pkg::SUR_LO_MIN || hacc_sh > jsvp_pkg::SUR_LO_MAX) begin
                                n_err   = jsvp_pkg::ST_SURR;
                                n_phase = jsvp_pkg::PH_ERR;
                            end else begin
                                v_cnt   = enc_sup.cnt;
                                v_data  = enc_sup.bytes;
                                n_phase = jsvp_pkg::PH_STR;
                            end
                        end else begin
                            n_hcnt = r_hcnt + 2'd1;
                        end
                    end
                end
                jsvp_pkg::PH_TRAIL: begin
                    if (!jsvp_pkg::is_ws(b)) begin
                        n_err   = jsvp_pkg::ST_NOTSING;
                        n_phase = jsvp_pkg::PH_ERR;
                    end
                end
                jsvp_pkg::PH_ERR: begin
                    n_phase = jsvp_pkg::PH_ERR;
                end
                default: begin
                    n_phase = jsvp_pkg::PH_LEAD;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < RES; i++) begin
            res_item[i].data = v_data[i];
            res_item[i].stat = v_stat;
            res_item[i].code = v_code;
            res_item[i].kind = v_kind;
            res_item[i].last = (v_cnt == jsvp_pkg::CNT_W'(i + 1));
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        for (int i = 0; i < RES; i++) begin
            n_item[i] = r_item[i];
        end
        if (in_acc) begin
            n_cnt = v_cnt;
            for (int i = 0; i < RES; i++) begin
                n_item[i] = res_item[i];
            end
        end else if (out_pop) begin
            n_cnt = r_cnt - jsvp_pkg::CNT_W'(1);
            for (int i = 0; i < RES - 1; i++) begin
                n_item[i] = r_item[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsvp_pkg::PH_LEAD;
            r_lpos  <= '0;
            r_err   <= jsvp_pkg::ST_OK;
            r_kind  <= jsvp_pkg::K_NULL;
            r_hacc  <= '0;
            r_hcnt  <= '0;
            r_hsur  <= '0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_phase <= n_phase;
                r_lpos  <= n_lpos;
                r_err   <= n_err;
                r_kind  <= n_kind;
                r_hacc  <= n_hacc;
                r_hcnt  <= n_hcnt;
                r_hsur  <= n_hsur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RES; i++) begin
            r_item[i] <= n_item[i];
        end
    end

    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= jsvp_pkg::CNT_W'(RES))
        else $error("Result buffer count out of range.");

    a_last_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_cnt == jsvp_pkg::CNT_W'(1)))
        else $error("Last result of a transaction is not the final buffered entry.");

    a_accept_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ((r_cnt == '0) || ((r_cnt == jsvp_pkg::CNT_W'(1)) && out_pop)))
        else $error("Input accepted while results are still pending.");

    a_end_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |=> (r_phase == jsvp_pkg::PH_LEAD && r_err == jsvp_pkg::ST_OK))
        else $error("Parser did not return to leading whitespace after end of text.");

    a_err_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == jsvp_pkg::PH_ERR) |-> (r_err != jsvp_pkg::ST_OK))
        else $error("Error phase without a latched error code.");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the JSON scalar value parser top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsvp_pkg::*;

    localparam int LONG_HOLD      = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    logic [PHASE_W-1:0] m_phase;
    logic [2:0]         m_lit_pos;
    logic [CODE_W-1:0]  m_err;
    logic [KIND_W-1:0]  m_kind;
    logic [15:0]        m_hex;
    logic [1:0]         m_hex_cnt;
    logic [9:0]         m_hi_sur;

    t_item      json_out_q[$];
    t_item      byte_out_q[$];
    logic [7:0] text_buf[$];

    int fail_cnt      = 0;
    int stall_cycles  = 0;
    int sink_hold     = 0;
    bit src_idle_en   = 1'b1;
    bit sink_stall_en = 1'b1;
    bit long_hold_req = 1'b0;

    json_scalar_value_parser_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void parser_clear();
        m_phase   = PH_LEAD;
        m_lit_pos = 3'd0;
        m_err     = ST_OK;
        m_kind    = K_NULL;
        m_hex     = 16'd0;
        m_hex_cnt = 2'd0;
        m_hi_sur  = 10'd0;
    endfunction

    function automatic bit json_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic bit dec_digit(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic logic [4:0] hex_digit_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            v = b - CH_0;
        end else if (b >= CH_UA && b <= CH_UF) begin
            v = b - CH_UA + 8'd10;
        end else if (b >= CH_LA && b <= CH_LF_) begin
            v = b - CH_LA + 8'd10;
        end else begin
            return 5'd0;
        end
        return {1'b1, v[3:0]};
    endfunction

    function automatic logic [2:0] word_len(input logic [KIND_W-1:0] k);
        return (k == K_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] word_char(input logic [KIND_W-1:0] k, input logic [2:0] p);
        string w;
        if (k == K_NULL) begin
            w = "null";
        end else if (k == K_FALSE) begin
            w = "false";
        end else begin
            w = "true";
        end
        return (p < w.len()) ? w[p] : 8'h00;
    endfunction

    function automatic void push_result(input logic [7:0] d, input logic s,
                                        input logic [CODE_W-1:0] c, input logic [KIND_W-1:0] k);
        t_item it;
        it.data = d;
        it.stat = s;
        it.code = c;
        it.kind = k;
        it.last = 1'b0;
        byte_out_q.push_back(it);
    endfunction

    function automatic void enter_error(input logic [CODE_W-1:0] c);
        m_err   = c;
        m_phase = PH_ERR;
    endfunction

    function automatic void emit_codepoint(input logic [20:0] u);
        if (u <= 21'h7F) begin
            push_result(u[7:0], 1'b0, ST_OK, K_NULL);
        end else if (u <= 21'h7FF) begin
            push_result(UTF_LEAD2 | {3'd0, u[10:6]}, 1'b0, ST_OK, K_NULL);
            push_result(UTF_CONT | {2'd0, u[5:0]}, 1'b0, ST_OK, K_NULL);
        end else if (u <= 21'hFFFF) begin
            push_result(UTF_LEAD3 | {4'd0, u[15:12]}, 1'b0, ST_OK, K_NULL);
            push_result(UTF_CONT | {2'd0, u[11:6]}, 1'b0, ST_OK, K_NULL);
            push_result(UTF_CONT | {2'd0, u[5:0]}, 1'b0, ST_OK, K_NULL);
        end else begin
            push_result(UTF_LEAD4 | {5'd0, u[20:18]}, 1'b0, ST_OK, K_NULL);
            push_result(UTF_CONT | {2'd0, u[17:12]}, 1'b0, ST_OK, K_NULL);
            push_result(UTF_CONT | {2'd0, u[11:6]}, 1'b0, ST_OK, K_NULL);
            push_result(UTF_CONT | {2'd0, u[5:0]}, 1'b0, ST_OK, K_NULL);
        end
    endfunction

    function automatic void close_number(input logic [7:0] b);
        m_kind = K_NUMBER;
        if (json_ws(b)) begin
            m_phase = PH_TRAIL;
        end else begin
            enter_error(ST_NOTSING);
        end
    endfunction

    function automatic bit take_hex_digit(input logic [7:0] b);
        logic [4:0] h;
        h = hex_digit_val(b);
        if (!h[4]) begin
            enter_error(ST_HEX);
            return 1'b0;
        end
        m_hex = {m_hex[11:0], h[3:0]};
        if (m_hex_cnt == 2'd3) begin
            m_hex_cnt = 2'd0;
            return 1'b1;
        end
        m_hex_cnt = m_hex_cnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void start_value(input logic [7:0] b);
        if (b == CH_LN || b == CH_LF_ || b == CH_LT) begin
            m_kind    = (b == CH_LN) ? K_NULL : (b == CH_LF_) ? K_FALSE : K_TRUE;
            m_lit_pos = 3'd1;
            m_phase   = PH_LIT;
        end else if (b == CH_QUOTE) begin
            m_phase = PH_STR;
        end else if (b == CH_MINUS) begin
            m_phase = PH_NSIGN;
        end else if (b == CH_0) begin
            m_phase = PH_NZERO;
        end else if (b >= CH_1 && b <= CH_9) begin
            m_phase = PH_NINT;
        end else begin
            enter_error(ST_INVALID);
        end
    endfunction

    function automatic void take_text_byte(input logic [7:0] b);
        case (m_phase)
            PH_LEAD: begin
                if (!json_ws(b)) start_value(b);
            end
            PH_LIT: begin
                if (m_lit_pos >= word_len(m_kind) || b != word_char(m_kind, m_lit_pos)) begin
                    enter_error(ST_INVALID);
                end else begin
                    m_lit_pos = m_lit_pos + 3'd1;
                    if (m_lit_pos == word_len(m_kind)) m_phase = PH_TRAIL;
                end
            end
            PH_NSIGN: begin
                if (b == CH_0) m_phase = PH_NZERO;
                else if (b >= CH_1 && b <= CH_9) m_phase = PH_NINT;
                else enter_error(ST_INVALID);
            end
            PH_NZERO, PH_NINT, PH_NFRAC: begin
                if (!(dec_digit(b) && m_phase != PH_NZERO)) begin
                    if (b == CH_DOT && m_phase != PH_NFRAC) m_phase = PH_NDOT;
                    else if (b == CH_LE || b == CH_UE) m_phase = PH_NE;
                    else close_number(b);
                end
            end
            PH_NDOT: begin
                if (dec_digit(b)) m_phase = PH_NFRAC;
                else enter_error(ST_INVALID);
            end
            PH_NE: begin
                if (b == CH_PLUS || b == CH_MINUS) m_phase = PH_NESIGN;
                else if (dec_digit(b)) m_phase = PH_NEXP;
                else enter_error(ST_INVALID);
            end
            PH_NESIGN: begin
                if (dec_digit(b)) m_phase = PH_NEXP;
                else enter_error(ST_INVALID);
            end
            PH_NEXP: begin
                if (!dec_digit(b)) close_number(b);
            end
            PH_STR: begin
                if (b == CH_QUOTE) begin
                    m_kind  = K_STRING;
                    m_phase = PH_TRAIL;
                end else if (b == CH_BSLASH) begin
                    m_phase = PH_ESC;
                end else if (b < CH_CTRL) begin
                    enter_error(ST_CHAR);
                end else begin
                    push_result(b, 1'b0, ST_OK, K_NULL);
                end
            end
            PH_ESC: begin
                m_phase = PH_STR;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: push_result(b, 1'b0, ST_OK, K_NULL);
                    CH_LB: push_result(ESC_BS, 1'b0, ST_OK, K_NULL);
                    CH_LF_: push_result(ESC_FF, 1'b0, ST_OK, K_NULL);
                    CH_LN: push_result(CH_LF, 1'b0, ST_OK, K_NULL);
                    CH_LR: push_result(CH_CR, 1'b0, ST_OK, K_NULL);
                    CH_LT: push_result(CH_TAB, 1'b0, ST_OK, K_NULL);
                    CH_LU: begin
                        m_hex     = 16'd0;
                        m_hex_cnt = 2'd0;
                        m_phase   = PH_HEX;
                    end
                    default: enter_error(ST_ESCAPE);
                endcase
            end
            PH_HEX: begin
                if (take_hex_digit(b)) begin
                    if (m_hex >= SUR_HI_MIN && m_hex <= SUR_HI_MAX) begin
                        m_hi_sur = m_hex[9:0];
                        m_phase  = PH_SURBS;
                    end else begin
                        emit_codepoint({5'd0, m_hex});
                        m_phase = PH_STR;
                    end
                end
            end
            PH_SURBS: begin
                if (b == CH_BSLASH) m_phase = PH_SURU;
                else enter_error(ST_SURR);
            end
            PH_SURU: begin
                if (b == CH_LU) begin
                    m_hex     = 16'd0;
                    m_hex_cnt = 2'd0;
                    m_phase   = PH_HEXLO;
                end else begin
                    enter_error(ST_SURR);
                end
            end
            PH_HEXLO: begin
                if (take_hex_digit(b)) begin
                    if (m_hex < SUR_LO_MIN || m_hex > SUR_LO_MAX) begin
                        enter_error(ST_SURR);
                    end else begin
                        emit_codepoint({1'b0, m_hi_sur, m_hex[9:0]} + SUPP_BASE);
                        m_phase = PH_STR;
                    end
                end
            end
            PH_TRAIL: begin
                if (!json_ws(b)) enter_error(ST_NOTSING);
            end
            PH_ERR: begin
            end
            default: m_phase = PH_LEAD;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] end_status();
        case (m_phase)
            PH_LEAD: return ST_EXPECT;
            PH_NZERO, PH_NINT, PH_NFRAC, PH_NEXP: begin
                m_kind = K_NUMBER;
                return ST_OK;
            end
            PH_STR: return ST_QUOTE;
            PH_ESC: return ST_ESCAPE;
            PH_HEX, PH_HEXLO: return ST_HEX;
            PH_SURBS, PH_SURU: return ST_SURR;
            PH_TRAIL: return ST_OK;
            PH_ERR: return m_err;
            default: return ST_INVALID;
        endcase
    endfunction

    function automatic void parse_json_byte(input logic [7:0] b, input logic eot);
        logic [CODE_W-1:0] c;
        t_item             it;
        byte_out_q.delete();
        if (eot) begin
            c = end_status();
            push_result(8'h00, 1'b1, c, (c == ST_OK) ? m_kind : K_NULL);
            parser_clear();
        end else begin
            take_text_byte(b);
        end
        if (byte_out_q.size() != 0) begin
            it = byte_out_q.pop_back();
            it.last = 1'b1;
            byte_out_q.push_back(it);
            foreach (byte_out_q[i]) json_out_q.push_back(byte_out_q[i]);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        parse_json_byte(b, eot);
        @(negedge i_clk);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
        send_end();
    endtask

    function automatic void push_chars(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_0 + {4'd0, n};
        return (($urandom_range(0, 1) == 0) ? CH_UA : CH_LA) + {4'd0, n} - 8'd10;
    endfunction

    function automatic void put_u_escape(input logic [15:0] v);
        text_buf.push_back(CH_BSLASH);
        text_buf.push_back(CH_LU);
        text_buf.push_back(hex_char(v[15:12]));
        text_buf.push_back(hex_char(v[11:8]));
        text_buf.push_back(hex_char(v[7:4]));
        text_buf.push_back(hex_char(v[3:0]));
    endfunction

    function automatic void put_digit();
        text_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
    endfunction

    function automatic void put_ws();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: text_buf.push_back(CH_SPACE);
                1: text_buf.push_back(CH_TAB);
                2: text_buf.push_back(CH_LF);
                default: text_buf.push_back(CH_CR);
            endcase
        end
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_MINUS);
        if ($urandom_range(0, 3) == 0) begin
            text_buf.push_back(CH_0);
        end else begin
            text_buf.push_back(8'(CH_1 + $urandom_range(0, 8)));
            repeat ($urandom_range(0, 3)) put_digit();
        end
        if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back(CH_DOT);
            repeat ($urandom_range(1, 3)) put_digit();
        end
        if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back(($urandom_range(0, 1) == 0) ? CH_LE : CH_UE);
            case ($urandom_range(0, 2))
                0: text_buf.push_back(CH_PLUS);
                1: text_buf.push_back(CH_MINUS);
                default: ;
            endcase
            repeat ($urandom_range(1, 2)) put_digit();
        end
    endfunction

    function automatic void put_string();
        logic [7:0]  c;
        logic [15:0] v;
        text_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    c = 8'($urandom_range(32, 255));
                    text_buf.push_back((c == CH_QUOTE || c == CH_BSLASH) ? CH_LA : c);
                end
                2: begin
                    text_buf.push_back(CH_BSLASH);
                    case ($urandom_range(0, 7))
                        0: text_buf.push_back(CH_QUOTE);
                        1: text_buf.push_back(CH_BSLASH);
                        2: text_buf.push_back(CH_SLASH);
                        3: text_buf.push_back(CH_LB);
                        4: text_buf.push_back(CH_LF_);
                        5: text_buf.push_back(CH_LN);
                        6: text_buf.push_back(CH_LR);
                        default: text_buf.push_back(CH_LT);
                    endcase
                end
                3: begin
                    v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2047))
                                                    : 16'($urandom_range(0, 65535));
                    put_u_escape(v);
                    if (v >= SUR_HI_MIN && v <= SUR_HI_MAX)
                        put_u_escape(16'($urandom_range(56320, 57343)));
                end
                4: begin
                    put_u_escape(16'($urandom_range(55296, 56319)));
                    put_u_escape(16'($urandom_range(56320, 57343)));
                end
                default: put_u_escape(16'($urandom_range(56320, 57343)));
            endcase
        end
        text_buf.push_back(CH_QUOTE);
    endfunction

    function automatic void build_text();
        int unsigned p;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        put_ws();
        case ($urandom_range(0, 4))
            0: push_chars("null");
            1: push_chars(($urandom_range(0, 1) == 0) ? "true" : "false");
            2: put_number();
            default: put_string();
        endcase
        put_ws();
        if ($urandom_range(0, 3) == 0) begin
            p = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: text_buf[p] = 8'($urandom_range(0, 255));
                1: while (text_buf.size() > p) void'(text_buf.pop_back());
                2: text_buf.push_back(8'($urandom_range(0, 255)));
                default: text_buf.insert(p, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic test_literals();
        send_text("null");
        send_text(" \ttrue\r\n");
        send_text("false");
        send_text("nul");
    endtask

    task automatic test_numbers();
        send_text("-0.5e+10");
        send_text("12E-3 ");
        send_text("0123");
        send_text("7e");
    endtask

    task automatic test_escapes();
        send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    endtask

    task automatic test_unicode();
        send_text("\"\\u0041\\u00e9\\u20AC\\uD83D\\uDE00\\uDC00\"");
        send_text("\"\\uDBFF\\uDFFF\\uFFFF\\u0000\"");
    endtask

    task automatic test_errors();
        send_end();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_end();
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_end();
        send_text("\"ab");
        send_text("\"\\");
        send_text("\"\\q\"");
        send_text("\"\\u1g");
        send_text("\"\\u12");
        send_text("\"\\uD800");
        send_text("\"\\uD800\\");
        send_text("\"\\uD800x");
        send_text("\"\\uD800\\u0041\"");
        send_text("1 2");
    endtask

    task automatic test_output_stall();
        long_hold_req = 1'b1;
        send_text("\"\\uD83D\\uDE00\\u20ACxy\"");
    endtask

    task automatic test_random_texts(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_text();
            foreach (text_buf[i]) send_byte(text_buf[i], 1'b0);
            send_end();
            sent += text_buf.size() + 1;
        end
    endtask

    task automatic test_no_idle();
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
        test_random_texts(12);
    endtask

    always @(negedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            sink_hold = LONG_HOLD - 1;
            i_m_axis_tready <= 1'b0;
        end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
            sink_hold = $urandom_range(0, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    function automatic void log_mismatch(input string what, input t_item want,
                                         input t_item got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t %s: expected data=%02h stat=%0b code=%0d kind=%0d last=%0b, got data=%02h stat=%0b code=%0d kind=%0d last=%0b tdata=%04h",
                     $realtime, what, want.data, want.stat, want.code, want.kind, want.last,
                     got.data, got.stat, got.code, got.kind, got.last, o_m_axis_tdata);
    endfunction

    always @(posedge i_clk) begin
        t_item got;
        t_item want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.data = o_m_axis_tdata[7:0];
            got.stat = o_m_axis_tuser;
            got.code = o_m_axis_tdata[11:8];
            got.kind = o_m_axis_tdata[14:12];
            got.last = o_m_axis_tlast;
            if (json_out_q.size() == 0) begin
                log_mismatch("unexpected transaction", '0, got);
            end else begin
                want = json_out_q.pop_front();
                if (got !== want || o_m_axis_tdata[15] !== 1'b0)
                    log_mismatch("mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[json_scalar_value_parser_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        parser_clear();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_literals();
        test_numbers();
        test_escapes();
        test_unicode();
        test_errors();
        test_output_stall();
        test_random_texts(12);
        test_no_idle();

        i_s_axis_tvalid <= 1'b0;
        while (json_out_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && json_out_q.size() == 0) begin
            $display("[json_scalar_value_parser_top] OK");
        end else begin
            $display("[json_scalar_value_parser_top] ERROR");
        end
        $finish;
    end

endmodule
